// ===== rtl/fwil_pkg.sv =====
`default_nettype none

package fwil_pkg;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_T = 8'h74;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_NO_VALUE = 2'd2;
    localparam logic [1:0] STATUS_EOI      = 2'd3;

    // Logical field progress
    localparam logic [1:0] LOG_NONE  = 2'd0;
    localparam logic [1:0] LOG_FALSE = 2'd1;
    localparam logic [1:0] LOG_TRUE  = 2'd2;

    // Field kinds, store sizes and the octal base
    localparam logic       KIND_INTEGER = 1'b0;
    localparam logic       KIND_LOGICAL = 1'b1;
    localparam logic [1:0] SIZE_BYTE    = 2'd0;
    localparam logic [1:0] SIZE_HALF    = 2'd1;
    localparam logic [3:0] BASE_OCTAL   = 4'd8;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_KIND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_AS_ZERO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_SIZE   = 3'd4;
    localparam int unsigned CFG_DATA_W = 8;

    typedef struct packed {
        logic       field_kind;
        logic [3:0] number_base;
        logic [7:0] field_width;
        logic       blank_as_zero;
        logic [1:0] result_size;
    } fwil_cfg_t;

    typedef struct packed {
        logic [31:0] value;
        logic        value_written;
        logic [1:0]  status;
    } fwil_result_t;

    // Apply sign, truncate to the store size and sign-extend
    function automatic logic [31:0] sized_value(input logic [31:0] acc,
                                                input logic        neg,
                                                input logic [1:0]  size);
        logic [31:0] x;
        logic [31:0] r;
        begin
            x = neg ? (32'd0 - acc) : acc;
            if (size == SIZE_BYTE) begin
                r = {{24{x[7]}}, x[7:0]};
            end else if (size == SIZE_HALF) begin
                r = {{16{x[15]}}, x[15:0]};
            end else begin
                r = x;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fwil_core.sv =====
`default_nettype none

module fwil_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  beat_in,
    input  wire logic [7:0]            character,
    input  wire logic                  end_of_input,
    input  wire fwil_pkg::fwil_cfg_t   cfg,
    output logic                       emit,
    output fwil_pkg::fwil_result_t     result
);
    import fwil_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [1:0]  log_reg, log_next;

    logic        is_octal;
    logic [31:0] acc_scaled;
    logic        is_digit;
    logic        is_blank;
    logic [7:0]  pos_inc;
    logic [7:0]  eff_width;
    logic        at_end;
    logic [3:0]  digit_code;

    // Scale by the radix with shifts and one add
    assign is_octal   = (cfg.number_base == BASE_OCTAL);
    assign acc_scaled = is_octal ? {acc_reg[28:0], 3'b000}
                                 : ({acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0});
    assign is_digit   = (character >= CH_ZERO) && (character <= CH_NINE);
    assign is_blank   = (character == CH_SPACE) || (character == CH_NEWLINE);
    // Digits '0'..'9' carry their value in the low nibble
    assign digit_code = character[3:0];
    assign pos_inc    = pos_reg + 8'd1;
    assign eff_width  = (cfg.field_width == 8'd0) ? 8'd1 : cfg.field_width;
    assign at_end     = (pos_inc >= eff_width) || (pos_inc == 8'd0);

    // Next field state and result for one character beat
    always_comb begin
        pos_next = pos_reg;
        acc_next = acc_reg;
        neg_next = neg_reg;
        log_next = log_reg;
        emit     = 1'b0;
        result   = '{value: 32'd0, value_written: 1'b0, status: STATUS_OK};
        if (beat_in) begin
            if (end_of_input) begin
                emit          = 1'b1;
                result.status = STATUS_EOI;
            end else if (cfg.field_kind == KIND_INTEGER) begin
                if (character == CH_COMMA) begin
                    emit                 = 1'b1;
                    result.value         = sized_value(acc_reg, neg_reg, cfg.result_size);
                    result.value_written = 1'b1;
                end else if (!(is_digit || is_blank || character == CH_MINUS
                               || character == CH_PLUS)) begin
                    emit          = 1'b1;
                    result.status = STATUS_BAD_CHAR;
                end else begin
                    if (character == CH_MINUS) begin
                        neg_next = 1'b1;
                    end else if (is_digit) begin
                        acc_next = acc_scaled + {28'd0, digit_code};
                    end else if (is_blank && cfg.blank_as_zero) begin
                        acc_next = acc_scaled;
                    end
                    pos_next = pos_inc;
                    if (at_end) begin
                        emit                 = 1'b1;
                        result.value         = sized_value(acc_next, neg_next,
                                                           cfg.result_size);
                        result.value_written = 1'b1;
                    end
                end
            end else begin
                if (character == CH_COMMA) begin
                    emit = 1'b1;
                end else begin
                    if (log_reg == LOG_NONE) begin
                        if (character == CH_LOWER_T) begin
                            log_next = LOG_TRUE;
                        end else if (character == CH_LOWER_F) begin
                            log_next = LOG_FALSE;
                        end
                    end
                    pos_next = pos_inc;
                    if (at_end) begin
                        emit = 1'b1;
                        if (log_next == LOG_NONE) begin
                            result.status = STATUS_NO_VALUE;
                        end else begin
                            result.value         = {31'd0, log_next == LOG_TRUE};
                            result.value_written = 1'b1;
                        end
                    end
                end
            end
            // Every result returns the field to its initial state
            if (emit) begin
                pos_next = 8'd0;
                acc_next = 32'd0;
                neg_next = 1'b0;
                log_next = LOG_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 8'd0;
            acc_reg <= 32'd0;
            neg_reg <= 1'b0;
            log_reg <= LOG_NONE;
        end else begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            neg_reg <= neg_next;
            log_reg <= log_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fixed_width_int_logical_field_reader.sv =====
// Fixed-width formatted field reader: integer (octal/decimal) and logical fields.
// Input channel s_*: one character per beat; s_tuser flags end of input.
// Result channel m_*: one beat per finished field, carrying the value in
// m_tdata and value_written/status in m_tuser.
// Configuration: write cfg_wdata into register cfg_index while cfg_we is high;
// registers take effect from the next character.
// A result appears on m_* in the cycle after the beat that ends the field
// (last character, comma, bad character or end of input).
// Throughput: one character per cycle while s_tready is high, set by the single
// radix multiply-add (shift and add) on the accumulator between the state and
// result registers. The receiver may stall: a finished result waits in the
// output register and s_tready stays high as long as that register is empty or
// being drained. Reset (aresetn low, synchronous) clears the field state,
// empties the output register and restores registers to integer, decimal,
// width 1, no blank-zero, word size.
`default_nettype none

module fixed_width_int_logical_field_reader (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // character beats
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] character
    input  wire logic                            s_tuser,   // [0] end_of_input
    // result beats
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [31:0]                          m_tdata,   // [31:0] value
    output logic [7:0]                           m_tuser,   // [0] value_written,
                                                             // [2:1] status
    // configuration writes
    input  wire logic                            cfg_we,
    input  wire logic [fwil_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fwil_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import fwil_pkg::*;

    fwil_cfg_t    cfg_reg;
    fwil_result_t res;
    fwil_result_t res_reg;
    logic         emit;
    logic         beat_in;
    logic         m_valid_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{field_kind: KIND_INTEGER, number_base: 4'd10,
                         field_width: 8'd1, blank_as_zero: 1'b0, result_size: 2'd2};
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FIELD_KIND:    cfg_reg.field_kind    <= cfg_wdata[0];
                CFG_NUMBER_BASE:   cfg_reg.number_base   <= cfg_wdata[3:0];
                CFG_FIELD_WIDTH:   cfg_reg.field_width   <= cfg_wdata[7:0];
                CFG_BLANK_AS_ZERO: cfg_reg.blank_as_zero <= cfg_wdata[0];
                CFG_RESULT_SIZE:   cfg_reg.result_size   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Accept while the output register is empty or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign beat_in  = s_tvalid && s_tready;

    fwil_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_in      (beat_in),
        .character    (s_tdata),
        .end_of_input (s_tuser),
        .cfg          (cfg_reg),
        .emit         (emit),
        .result       (res)
    );

    // Output register: load on a finished field, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && emit) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg.value;
    assign m_tuser  = {5'd0, res_reg.status, res_reg.value_written};

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import fwil_pkg::*;

    localparam int ITEM_TARGET   = 2000;
    localparam int QUIET_FROM    = 1750;
    localparam int SETTLE_CYCLES = 4;

    // Tracks the field in progress and the results it must produce
    class field_scoreboard;
        logic        field_kind;
        logic [3:0]  number_base;
        logic [7:0]  field_width;
        logic        blank_as_zero;
        logic [1:0]  result_size;

        logic [7:0]  char_pos;
        logic [31:0] acc;
        logic        neg;
        logic [1:0]  log_state;

        fwil_result_t expected_fields[$];
        int           error_count;

        function new();
            field_kind    = KIND_INTEGER;
            number_base   = 4'd10;
            field_width   = 8'd1;
            blank_as_zero = 1'b0;
            result_size   = 2'd2;
            error_count   = 0;
            clear_field();
        endfunction

        function void clear_field();
            char_pos  = '0;
            acc       = '0;
            neg       = 1'b0;
            log_state = LOG_NONE;
        endfunction

        function void reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FIELD_KIND:    field_kind    = data[0];
                CFG_NUMBER_BASE:   number_base   = data[3:0];
                CFG_FIELD_WIDTH:   field_width   = data[7:0];
                CFG_BLANK_AS_ZERO: blank_as_zero = data[0];
                CFG_RESULT_SIZE:   result_size   = data[1:0];
                default: ;
            endcase
        endfunction

        // Apply the sign, then truncate and sign-extend to the store size
        function logic [31:0] stored_value();
            logic [31:0] x;
            x = neg ? (32'd0 - acc) : acc;
            case (result_size)
                SIZE_BYTE: return 32'($signed(x[7:0]));
                SIZE_HALF: return 32'($signed(x[15:0]));
                default:   return x;
            endcase
        endfunction

        // Width 0 acts as 1; a wrapped position also closes the field
        function bit width_reached();
            logic [7:0] w;
            w = (field_width == 8'd0) ? 8'd1 : field_width;
            return (char_pos >= w) || (char_pos == 8'd0);
        endfunction

        function void close_field(logic [31:0] value, logic written, logic [1:0] status);
            fwil_result_t r;
            r.value         = value;
            r.value_written = written;
            r.status        = status;
            expected_fields.push_back(r);
            clear_field();
        endfunction

        function void take_char(logic [7:0] ch, logic eoi);
            logic [31:0] radix;
            radix = (number_base == BASE_OCTAL) ? 32'd8 : 32'd10;
            if (eoi) begin
                close_field(32'd0, 1'b0, STATUS_EOI);
                return;
            end
            if (field_kind == KIND_INTEGER) begin
                if (ch == CH_COMMA) begin
                    close_field(stored_value(), 1'b1, STATUS_OK);
                    return;
                end
                if (ch == CH_MINUS) begin
                    neg = 1'b1;
                end else if (ch == CH_SPACE || ch == CH_NEWLINE) begin
                    if (blank_as_zero)
                        acc = acc * radix;
                end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    acc = acc * radix + 32'(ch - CH_ZERO);
                end else if (ch != CH_PLUS) begin
                    close_field(32'd0, 1'b0, STATUS_BAD_CHAR);
                    return;
                end
                char_pos = char_pos + 8'd1;
                if (width_reached())
                    close_field(stored_value(), 1'b1, STATUS_OK);
            end else begin
                if (ch == CH_COMMA) begin
                    close_field(32'd0, 1'b0, STATUS_OK);
                    return;
                end
                if (log_state == LOG_NONE) begin
                    if (ch == CH_LOWER_T)
                        log_state = LOG_TRUE;
                    else if (ch == CH_LOWER_F)
                        log_state = LOG_FALSE;
                end
                char_pos = char_pos + 8'd1;
                if (width_reached()) begin
                    if (log_state == LOG_NONE)
                        close_field(32'd0, 1'b0, STATUS_NO_VALUE);
                    else
                        close_field((log_state == LOG_TRUE) ? 32'd1 : 32'd0, 1'b1, STATUS_OK);
                end
            end
        endfunction

        function void check_field(logic [31:0] value, logic [7:0] tuser);
            fwil_result_t e;
            if (expected_fields.size() == 0) begin
                $display("%0t: unexpected result beat: value %h, tuser %h",
                         $time, value, tuser);
                error_count++;
                return;
            end
            e = expected_fields.pop_front();
            if (value !== e.value) begin
                $display("%0t: value mismatch: expected %h, actual %h", $time, e.value, value);
                error_count++;
            end
            if (tuser[0] !== e.value_written) begin
                $display("%0t: value_written mismatch: expected %0d, actual %0d",
                         $time, e.value_written, tuser[0]);
                error_count++;
            end
            if (tuser[2:1] !== e.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, e.status, tuser[2:1]);
                error_count++;
            end
        endfunction

        function int pending_count();
            return expected_fields.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'd0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic [7:0]            m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    field_scoreboard sb = new();

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int sink_hold     = 0;
    int chars_sent    = 0;

    fixed_width_int_logical_field_reader u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watch both channels and the register port; results first, then new beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_field(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.take_char(s_tdata, s_tuser);
            if (cfg_we)
                sb.reg_write(cfg_index, cfg_wdata);
        end
    end

    // Result sink: long hold-off on request, otherwise random stall bursts
    initial begin : result_sink
        int gap;
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
                m_tready <= 1'b1;
            end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                gap = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one character beat and hold it until accepted; valid stays high
    task automatic send_char(input logic [7:0] ch, input logic eoi);
        int gap;
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], 1'b0);
    endtask

    // Drop valid, let the monitor see the last beat, drain every pending result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all five registers back to back; unused data bits carry junk
    task automatic load_setup(input logic kind, input logic [3:0] base,
                              input logic [7:0] width, input logic blank,
                              input logic [1:0] size);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIELD_KIND;
        cfg_wdata <= {7'($urandom), kind};
        @(posedge aclk);
        cfg_index <= CFG_NUMBER_BASE;
        cfg_wdata <= {4'($urandom), base};
        @(posedge aclk);
        cfg_index <= CFG_FIELD_WIDTH;
        cfg_wdata <= width;
        @(posedge aclk);
        cfg_index <= CFG_BLANK_AS_ZERO;
        cfg_wdata <= {7'($urandom), blank};
        @(posedge aclk);
        cfg_index <= CFG_RESULT_SIZE;
        cfg_wdata <= {6'($urandom), size};
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed characters for the field kind, some noise
    function automatic logic [7:0] pick_char(input logic kind);
        int r;
        r = $urandom_range(0, 99);
        if (kind == KIND_INTEGER) begin
            if (r < 70) return CH_ZERO + 8'($urandom_range(0, 9));
            if (r < 76) return CH_MINUS;
            if (r < 80) return CH_PLUS;
            if (r < 86) return CH_SPACE;
            if (r < 89) return CH_NEWLINE;
            if (r < 93) return CH_COMMA;
            return 8'($urandom);
        end
        if (r < 15) return CH_LOWER_T;
        if (r < 30) return CH_LOWER_F;
        if (r < 36) return CH_COMMA;
        return 8'($urandom);
    endfunction

    initial begin : stimulus
        int          phase;
        int          phase_len;
        logic        kind;
        logic [3:0]  base;
        logic [7:0]  width;
        logic        eoi;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Integer: sign anywhere, plus and blank ignored, bad char, early end of input
        load_setup(KIND_INTEGER, 4'd10, 8'd4, 1'b0, 2'd2);
        send_text("-+ 5");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        // Octal with digits 8 and 9, newline as zero digit, byte store
        settle();
        load_setup(KIND_INTEGER, BASE_OCTAL, 8'd3, 1'b1, SIZE_BYTE);
        send_text("9\n8");
        // Accumulator wrap in a full word
        settle();
        load_setup(KIND_INTEGER, 4'd10, 8'd10, 1'b0, 2'd2);
        send_text("9999999999");
        // Logical: first t wins, comma with no value, no t or f, end of input mid-field
        settle();
        load_setup(KIND_LOGICAL, 4'd10, 8'd3, 1'b0, 2'd3);
        send_text("qtf");
        send_text(",");
        send_char(8'h61, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h74, 1'b0);
        send_char(8'h00, 1'b1);

        // Random phases, each with its own register setting
        phase = 0;
        while (chars_sent < ITEM_TARGET) begin
            settle();
            kind = 1'($urandom);
            case ($urandom_range(0, 2))
                0: base = BASE_OCTAL;
                1: base = 4'd10;
                default: base = 4'($urandom);
            endcase
            case ($urandom_range(0, 19))
                0:       width = 8'd255;
                1:       width = 8'd0;
                2, 3:    width = 8'($urandom_range(13, 40));
                default: width = 8'($urandom_range(1, 12));
            endcase
            // Short integer fields so results pile up behind the stalled sink
            if (phase == 0) begin
                kind  = KIND_INTEGER;
                width = 8'd2;
            end
            if (phase == 1) width = 8'd255;
            if (phase == 2) width = 8'd0;
            load_setup(kind, base, width, 1'($urandom), 2'($urandom));

            if (chars_sent >= QUIET_FROM) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = (phase % 4 == 3) ? 0 : $urandom_range(0, 40);
                sink_idle_pct = (phase % 5 == 4) ? 0 : $urandom_range(0, 40);
            end
            // Back up the result channel long enough to stall the input
            if (phase == 0)
                sink_hold = 300;

            phase_len = $urandom_range(40, 150);
            repeat (phase_len) begin
                eoi = ($urandom_range(0, 99) == 0);
                send_char(eoi ? 8'($urandom) : pick_char(kind), eoi);
            end
            phase++;
        end

        settle();
        repeat (10) @(posedge aclk);
        if (sb.error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
